// ----- hw/rtl/psag_pkg.sv -----
// Shared types, widths and constant tables of the pixel shuffle address generator.
// Used by psag_odometer and pixel_shuffle_address_generator; depends on nothing.
`default_nettype none

package psag_pkg;

  localparam int unsigned ADDR_BITS_DEF  = 32;
  localparam int unsigned MAX_FACTOR_DEF = 8;

  localparam int unsigned SCALE_W  = 4;
  localparam int unsigned CHAN_W   = 11;
  localparam int unsigned HEIGHT_W = 13;
  localparam int unsigned WIDTH_W  = 13;
  localparam int unsigned BATCH_W  = 9;

  localparam int unsigned CHAN_MAX   = 1024;
  localparam int unsigned HEIGHT_MAX = 4096;
  localparam int unsigned WIDTH_MAX  = 4096;
  localparam int unsigned BATCH_MAX  = 256;

  localparam int unsigned BATCH_DW = 8;
  localparam int unsigned CHAN_DW  = 10;
  localparam int unsigned ROW_DW   = 12;
  localparam int unsigned COL_DW   = 12;
  localparam int unsigned CMP_W    = 13;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned WIDX_W     = 32;
  localparam int unsigned OFFSET_W   = 32;

  localparam int unsigned NUM_DIGITS = 6;
  localparam int unsigned DIG_BATCH  = 0;
  localparam int unsigned DIG_CHAN   = 1;
  localparam int unsigned DIG_ROW    = 2;
  localparam int unsigned DIG_SUBROW = 3;
  localparam int unsigned DIG_COL    = 4;
  localparam int unsigned DIG_SUBCOL = 5;

  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAYOUT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BATCH     = 3'd6;

  typedef enum logic [1:0] {
    MODE_SHUF_NCHW   = 2'd0,
    MODE_SHUF_NHWC   = 2'd1,
    MODE_UNSHUF_NCHW = 2'd2,
    MODE_UNSHUF_NHWC = 2'd3
  } walk_mode_e;

  // place of each digit in the walk, 0 innermost; rows are modes, columns digits
  localparam logic [2:0] DIGIT_POS [4][NUM_DIGITS] = '{
    '{3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0},
    '{3'd5, 3'd0, 3'd4, 3'd3, 3'd2, 3'd1},
    '{3'd5, 3'd4, 3'd1, 3'd3, 3'd0, 3'd2},
    '{3'd5, 3'd2, 3'd4, 3'd1, 3'd3, 3'd0}
  };

  typedef struct packed {
    logic                direction;
    logic                layout;
    logic [SCALE_W-1:0]  scale;
    logic [CHAN_W-1:0]   chans;
    logic [HEIGHT_W-1:0] height;
    logic [WIDTH_W-1:0]  width;
    logic [BATCH_W-1:0]  batch;
  } cfg_t;

  typedef struct packed {
    walk_mode_e          mode;
    logic [SCALE_W-1:0]  s;
    logic [CHAN_W-1:0]   c;
    logic [HEIGHT_W-1:0] h;
    logic [WIDTH_W-1:0]  w;
    logic [BATCH_W-1:0]  n;
  } snap_t;

  typedef struct packed {
    logic                  start;
    logic [NUM_DIGITS-1:0] inc;
    logic [NUM_DIGITS-1:0] clr;
    logic                  last;
    logic [WIDX_W-1:0]     windex;
  } step_t;

  typedef struct packed {
    step_t step;
    snap_t snap;
  } item_t;

  function automatic logic [NUM_DIGITS-1:0] inner_mask(walk_mode_e mode, int unsigned k);
    logic [NUM_DIGITS-1:0] m;
    m = '0;
    for (int unsigned j = 0; j < NUM_DIGITS; j++) begin
      m[j] = DIGIT_POS[mode][j] < DIGIT_POS[mode][k];
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/psag_odometer.sv -----
// Six-digit output walk of the pixel shuffle address generator: digits, write index,
// limits latched at start, and the per-digit step masks. Depends on psag_pkg.
`default_nettype none

module psag_odometer #(
  parameter int unsigned MAX_FACTOR = psag_pkg::MAX_FACTOR_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            advance_i,
  input  logic            restart_i,
  input  psag_pkg::cfg_t  cfg_i,
  output psag_pkg::item_t item_o
);
  import psag_pkg::*;

  localparam int unsigned SubW = $clog2(MAX_FACTOR);

  logic                  at_start_q;
  logic [BATCH_DW-1:0]   batch_q;
  logic [CHAN_DW-1:0]    chan_q;
  logic [ROW_DW-1:0]     row_q;
  logic [SubW-1:0]       subrow_q;
  logic [COL_DW-1:0]     col_q;
  logic [SubW-1:0]       subcol_q;
  logic [WIDX_W-1:0]     dcount_q;
  snap_t                 snap_q;
  logic [NUM_DIGITS-1:0] pend_inc_q;
  logic [NUM_DIGITS-1:0] pend_clr_q;

  logic                  start;
  snap_t                 live_snap;
  snap_t                 snap;
  logic [CMP_W-1:0]      cur [NUM_DIGITS];
  logic [CMP_W-1:0]      lim [NUM_DIGITS];
  logic [CMP_W-1:0]      nxt [NUM_DIGITS];
  logic [NUM_DIGITS-1:0] wrap;
  logic [NUM_DIGITS-1:0] inc;
  logic [NUM_DIGITS-1:0] clr;
  logic                  last;
  logic [WIDX_W-1:0]     widx;

  assign start = restart_i | at_start_q;

  always_comb begin
    live_snap.mode = walk_mode_e'({cfg_i.direction, cfg_i.layout});
    if (cfg_i.scale == '0) begin
      live_snap.s = SCALE_W'(1);
    end else if (5'(cfg_i.scale) > 5'(MAX_FACTOR)) begin
      live_snap.s = SCALE_W'(MAX_FACTOR);
    end else begin
      live_snap.s = cfg_i.scale;
    end
    if (cfg_i.chans == '0) begin
      live_snap.c = CHAN_W'(1);
    end else if (cfg_i.chans > CHAN_W'(CHAN_MAX)) begin
      live_snap.c = CHAN_W'(CHAN_MAX);
    end else begin
      live_snap.c = cfg_i.chans;
    end
    if (cfg_i.height == '0) begin
      live_snap.h = HEIGHT_W'(1);
    end else if (cfg_i.height > HEIGHT_W'(HEIGHT_MAX)) begin
      live_snap.h = HEIGHT_W'(HEIGHT_MAX);
    end else begin
      live_snap.h = cfg_i.height;
    end
    if (cfg_i.width == '0) begin
      live_snap.w = WIDTH_W'(1);
    end else if (cfg_i.width > WIDTH_W'(WIDTH_MAX)) begin
      live_snap.w = WIDTH_W'(WIDTH_MAX);
    end else begin
      live_snap.w = cfg_i.width;
    end
    if (cfg_i.batch == '0) begin
      live_snap.n = BATCH_W'(1);
    end else if (cfg_i.batch > BATCH_W'(BATCH_MAX)) begin
      live_snap.n = BATCH_W'(BATCH_MAX);
    end else begin
      live_snap.n = cfg_i.batch;
    end
  end

  assign snap = start ? live_snap : snap_q;

  always_comb begin
    cur[DIG_BATCH]  = start ? '0 : CMP_W'(batch_q);
    cur[DIG_CHAN]   = start ? '0 : CMP_W'(chan_q);
    cur[DIG_ROW]    = start ? '0 : CMP_W'(row_q);
    cur[DIG_SUBROW] = start ? '0 : CMP_W'(subrow_q);
    cur[DIG_COL]    = start ? '0 : CMP_W'(col_q);
    cur[DIG_SUBCOL] = start ? '0 : CMP_W'(subcol_q);
    lim[DIG_BATCH]  = CMP_W'(snap.n);
    lim[DIG_CHAN]   = CMP_W'(snap.c);
    lim[DIG_ROW]    = CMP_W'(snap.h);
    lim[DIG_SUBROW] = CMP_W'(snap.s);
    lim[DIG_COL]    = CMP_W'(snap.w);
    lim[DIG_SUBCOL] = CMP_W'(snap.s);
    for (int unsigned k = 0; k < NUM_DIGITS; k++) begin
      wrap[k] = (cur[k] + CMP_W'(1)) >= lim[k];
    end
    for (int unsigned k = 0; k < NUM_DIGITS; k++) begin
      inc[k] = (&(wrap | ~inner_mask(snap.mode, k))) & ~wrap[k];
      clr[k] = (&(wrap | ~inner_mask(snap.mode, k))) & wrap[k];
      if (clr[k]) begin
        nxt[k] = '0;
      end else if (inc[k]) begin
        nxt[k] = cur[k] + CMP_W'(1);
      end else begin
        nxt[k] = cur[k];
      end
    end
    last = &wrap;
    widx = start ? '0 : dcount_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q <= 1'b1;
      batch_q    <= '0;
      chan_q     <= '0;
      row_q      <= '0;
      subrow_q   <= '0;
      col_q      <= '0;
      subcol_q   <= '0;
      dcount_q   <= '0;
    end else if (advance_i) begin
      at_start_q <= last;
      batch_q    <= BATCH_DW'(nxt[DIG_BATCH]);
      chan_q     <= CHAN_DW'(nxt[DIG_CHAN]);
      row_q      <= ROW_DW'(nxt[DIG_ROW]);
      subrow_q   <= SubW'(nxt[DIG_SUBROW]);
      col_q      <= COL_DW'(nxt[DIG_COL]);
      subcol_q   <= SubW'(nxt[DIG_SUBCOL]);
      dcount_q   <= last ? '0 : widx + WIDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      snap_q     <= snap;
      pend_inc_q <= inc;
      pend_clr_q <= clr;
    end
  end

  always_comb begin
    item_o.step.start  = start;
    item_o.step.inc    = pend_inc_q;
    item_o.step.clr    = pend_clr_q;
    item_o.step.last   = last;
    item_o.step.windex = widx;
    item_o.snap        = snap;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/pixel_shuffle_address_generator.sv -----
// Top level of the pixel shuffle / unshuffle gather address generator: registers,
// stride pipeline and offset accumulation. Depends on psag_pkg and psag_odometer.
//
// Usage: write the seven registers through cfg_we_i / cfg_index_i / cfg_wdata_i while
// the block is idle. Each word taken on the input channel (in_valid_i / in_ready_o)
// produces one word on the output channel (out_valid_o / out_ready_i): the read offset
// into the source tensor, the linear write index and a last flag on the final element.
// restart_i set on a word returns the walk to element zero; the registers are sampled
// at that point, after reset and after the final element.
// One word per cycle is sustained while out_ready_i stays high. The per-digit strides
// are formed by the multipliers of stages 2 to 4, which travel with every word, so a
// new walk costs no bubble.
// Reset empties the pipeline and sets the registers to shuffle, contiguous, factor 2,
// all sizes 1. When the receiver stalls, the output word holds and the stages in
// front of it keep filling; input ready drops only once every stage is full.
`default_nettype none

module pixel_shuffle_address_generator #(
  parameter int unsigned ADDR_BITS  = psag_pkg::ADDR_BITS_DEF,
  parameter int unsigned MAX_FACTOR = psag_pkg::MAX_FACTOR_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [psag_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [psag_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            restart_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [psag_pkg::OFFSET_W-1:0]   read_offset_o,
  output logic [psag_pkg::WIDX_W-1:0]     write_index_o,
  output logic                            last_o
);
  import psag_pkg::*;

  localparam int unsigned SS_W   = 2 * SCALE_W;
  localparam int unsigned HW_W   = HEIGHT_W + WIDTH_W;
  localparam int unsigned SC_W   = SCALE_W + CHAN_W;
  localparam int unsigned WS_W   = WIDTH_W + SCALE_W;
  localparam int unsigned CSS_W  = SS_W + CHAN_W;
  localparam int unsigned SSHW_W = SS_W + HW_W;
  localparam int unsigned SHW_W  = SCALE_W + HW_W;
  localparam int unsigned SSW_W  = SS_W + WIDTH_W;
  localparam int unsigned WSC_W  = WS_W + CHAN_W;
  localparam int unsigned CSHW_W = CSS_W + HW_W;
  localparam int unsigned WCSS_W = CSS_W + WIDTH_W;

  cfg_t  cfg_q;
  item_t item;

  logic en1, en2, en3, en4, en5, en6, en7;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;

  item_t item1_q;

  step_t               step2_q;
  walk_mode_e          mode2_q;
  logic [SCALE_W-1:0]  s2_q;
  logic [CHAN_W-1:0]   c2_q;
  logic [WIDTH_W-1:0]  w2_q;
  logic [SS_W-1:0]     ss2_q;
  logic [HW_W-1:0]     hw2_q;
  logic [SC_W-1:0]     sc2_q;
  logic [WS_W-1:0]     ws2_q;

  step_t               step3_q;
  walk_mode_e          mode3_q;
  logic [SCALE_W-1:0]  s3_q;
  logic [CHAN_W-1:0]   c3_q;
  logic [WIDTH_W-1:0]  w3_q;
  logic [SS_W-1:0]     ss3_q;
  logic [HW_W-1:0]     hw3_q;
  logic [SC_W-1:0]     sc3_q;
  logic [WS_W-1:0]     ws3_q;
  logic [CSS_W-1:0]    css3_q;
  logic [SSHW_W-1:0]   sshw3_q;
  logic [SHW_W-1:0]    shw3_q;
  logic [SSW_W-1:0]    ssw3_q;
  logic [WSC_W-1:0]    wsc3_q;

  logic [CSHW_W-1:0]    cshw;
  logic [WCSS_W-1:0]    wcss;
  logic [ADDR_BITS-1:0] st_d [NUM_DIGITS];
  logic [ADDR_BITS-1:0] st4_q [NUM_DIGITS];
  step_t                step4_q;

  logic [ADDR_BITS-1:0] part_q [NUM_DIGITS];
  logic                 last5_q;
  logic [WIDX_W-1:0]    widx5_q;

  logic [ADDR_BITS-1:0] sum_a_q, sum_b_q, sum_c_q;
  logic                 last6_q;
  logic [WIDX_W-1:0]    widx6_q;

  logic [ADDR_BITS-1:0] offset_q;
  logic                 last7_q;
  logic [WIDX_W-1:0]    widx7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.direction <= 1'b0;
      cfg_q.layout    <= 1'b0;
      cfg_q.scale     <= SCALE_W'(2);
      cfg_q.chans     <= CHAN_W'(1);
      cfg_q.height    <= HEIGHT_W'(1);
      cfg_q.width     <= WIDTH_W'(1);
      cfg_q.batch     <= BATCH_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_DIRECTION: cfg_q.direction <= cfg_wdata_i[0];
        REG_LAYOUT:    cfg_q.layout    <= cfg_wdata_i[0];
        REG_SCALE:     cfg_q.scale     <= cfg_wdata_i[SCALE_W-1:0];
        REG_CHANNELS:  cfg_q.chans     <= cfg_wdata_i[CHAN_W-1:0];
        REG_HEIGHT:    cfg_q.height    <= cfg_wdata_i[HEIGHT_W-1:0];
        REG_WIDTH:     cfg_q.width     <= cfg_wdata_i[WIDTH_W-1:0];
        REG_BATCH:     cfg_q.batch     <= cfg_wdata_i[BATCH_W-1:0];
        default:       cfg_q           <= cfg_q;
      endcase
    end
  end

  assign en7 = !v7_q | out_ready_i;
  assign en6 = !v6_q | en7;
  assign en5 = !v5_q | en6;
  assign en4 = !v4_q | en5;
  assign en3 = !v3_q | en4;
  assign en2 = !v2_q | en3;
  assign en1 = !v1_q | en2;
  assign in_ready_o = en1;

  psag_odometer #(
    .MAX_FACTOR(MAX_FACTOR)
  ) u_odometer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (in_valid_i & en1),
    .restart_i (restart_i),
    .cfg_i     (cfg_q),
    .item_o    (item)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
      if (en7) v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      item1_q <= item;
    end
    if (en2) begin
      step2_q <= item1_q.step;
      mode2_q <= item1_q.snap.mode;
      s2_q    <= item1_q.snap.s;
      c2_q    <= item1_q.snap.c;
      w2_q    <= item1_q.snap.w;
      ss2_q   <= SS_W'(item1_q.snap.s) * SS_W'(item1_q.snap.s);
      hw2_q   <= HW_W'(item1_q.snap.h) * HW_W'(item1_q.snap.w);
      sc2_q   <= SC_W'(item1_q.snap.s) * SC_W'(item1_q.snap.c);
      ws2_q   <= WS_W'(item1_q.snap.w) * WS_W'(item1_q.snap.s);
    end
    if (en3) begin
      step3_q <= step2_q;
      mode3_q <= mode2_q;
      s3_q    <= s2_q;
      c3_q    <= c2_q;
      w3_q    <= w2_q;
      ss3_q   <= ss2_q;
      hw3_q   <= hw2_q;
      sc3_q   <= sc2_q;
      ws3_q   <= ws2_q;
      css3_q  <= CSS_W'(ss2_q) * CSS_W'(c2_q);
      sshw3_q <= SSHW_W'(ss2_q) * SSHW_W'(hw2_q);
      shw3_q  <= SHW_W'(s2_q) * SHW_W'(hw2_q);
      ssw3_q  <= SSW_W'(ss2_q) * SSW_W'(w2_q);
      wsc3_q  <= WSC_W'(ws2_q) * WSC_W'(c2_q);
    end
  end

  assign cshw = CSHW_W'(css3_q) * CSHW_W'(hw3_q);
  assign wcss = WCSS_W'(css3_q) * WCSS_W'(w3_q);

  always_comb begin
    st_d[DIG_BATCH] = ADDR_BITS'(cshw);
    unique case (mode3_q)
      MODE_SHUF_NCHW: begin
        st_d[DIG_CHAN]   = ADDR_BITS'(sshw3_q);
        st_d[DIG_ROW]    = ADDR_BITS'(w3_q);
        st_d[DIG_SUBROW] = ADDR_BITS'(shw3_q);
        st_d[DIG_COL]    = ADDR_BITS'(1);
        st_d[DIG_SUBCOL] = ADDR_BITS'(hw3_q);
      end
      MODE_SHUF_NHWC: begin
        st_d[DIG_CHAN]   = ADDR_BITS'(ss3_q);
        st_d[DIG_ROW]    = ADDR_BITS'(wcss);
        st_d[DIG_SUBROW] = ADDR_BITS'(s3_q);
        st_d[DIG_COL]    = ADDR_BITS'(css3_q);
        st_d[DIG_SUBCOL] = ADDR_BITS'(1);
      end
      MODE_UNSHUF_NCHW: begin
        st_d[DIG_CHAN]   = ADDR_BITS'(sshw3_q);
        st_d[DIG_ROW]    = ADDR_BITS'(ssw3_q);
        st_d[DIG_SUBROW] = ADDR_BITS'(ws3_q);
        st_d[DIG_COL]    = ADDR_BITS'(s3_q);
        st_d[DIG_SUBCOL] = ADDR_BITS'(1);
      end
      MODE_UNSHUF_NHWC: begin
        st_d[DIG_CHAN]   = ADDR_BITS'(1);
        st_d[DIG_ROW]    = ADDR_BITS'(wcss);
        st_d[DIG_SUBROW] = ADDR_BITS'(wsc3_q);
        st_d[DIG_COL]    = ADDR_BITS'(sc3_q);
        st_d[DIG_SUBCOL] = ADDR_BITS'(c3_q);
      end
      default: begin
        st_d[DIG_CHAN]   = '0;
        st_d[DIG_ROW]    = '0;
        st_d[DIG_SUBROW] = '0;
        st_d[DIG_COL]    = '0;
        st_d[DIG_SUBCOL] = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      step4_q <= step3_q;
      for (int unsigned k = 0; k < NUM_DIGITS; k++) begin
        st4_q[k] <= st_d[k];
      end
    end
    // advance each digit's share of the offset as the word enters stage 5
    if (en5 && v4_q) begin
      for (int unsigned k = 0; k < NUM_DIGITS; k++) begin
        if (step4_q.start || step4_q.clr[k]) begin
          part_q[k] <= '0;
        end else if (step4_q.inc[k]) begin
          part_q[k] <= part_q[k] + st4_q[k];
        end
      end
    end
    if (en5) begin
      last5_q <= step4_q.last;
      widx5_q <= step4_q.windex;
    end
    if (en6) begin
      sum_a_q <= part_q[DIG_BATCH] + part_q[DIG_CHAN];
      sum_b_q <= part_q[DIG_ROW] + part_q[DIG_SUBROW];
      sum_c_q <= part_q[DIG_COL] + part_q[DIG_SUBCOL];
      last6_q <= last5_q;
      widx6_q <= widx5_q;
    end
    if (en7) begin
      offset_q <= sum_a_q + sum_b_q + sum_c_q;
      last7_q  <= last6_q;
      widx7_q  <= widx6_q;
    end
  end

  assign out_valid_o   = v7_q;
  assign read_offset_o = OFFSET_W'(offset_q);
  assign write_index_o = widx7_q;
  assign last_o        = last7_q;

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for pixel_shuffle_address_generator: predicts every output
// word from its own odometer model and compares it with the word the block returns.
// Depends on psag_pkg and the RTL of the block only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import psag_pkg::*;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned DIRECTED_WORDS = 27;
  localparam int unsigned RANDOM_WORDS = 1650;

  // digits from innermost to outermost, one row per walk mode
  localparam int unsigned WALK_ORDER [4][NUM_DIGITS] = '{
    '{DIG_SUBCOL, DIG_COL, DIG_SUBROW, DIG_ROW, DIG_CHAN, DIG_BATCH},
    '{DIG_CHAN, DIG_SUBCOL, DIG_COL, DIG_SUBROW, DIG_ROW, DIG_BATCH},
    '{DIG_COL, DIG_ROW, DIG_SUBCOL, DIG_SUBROW, DIG_CHAN, DIG_BATCH},
    '{DIG_SUBCOL, DIG_SUBROW, DIG_CHAN, DIG_COL, DIG_ROW, DIG_BATCH}
  };

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [WIDX_W-1:0]   windex;
    logic                last;
  } addr_word_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic                  restart_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [OFFSET_W-1:0]   read_offset_o;
  logic [WIDX_W-1:0]     write_index_o;
  logic                  last_o;

  pixel_shuffle_address_generator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .restart_i     (restart_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .read_offset_o (read_offset_o),
    .write_index_o (write_index_o),
    .last_o        (last_o)
  );

  always #10 clk_i = ~clk_i;

  // register copies
  logic                cfg_dir = 1'b0;
  logic                cfg_lay = 1'b0;
  logic [SCALE_W-1:0]  cfg_scale = 4'd2;
  logic [CHAN_W-1:0]   cfg_chans = 11'd1;
  logic [HEIGHT_W-1:0] cfg_height = 13'd1;
  logic [WIDTH_W-1:0]  cfg_width = 13'd1;
  logic [BATCH_W-1:0]  cfg_batch = 9'd1;

  // odometer copy
  int unsigned         walk_digit [NUM_DIGITS];
  int unsigned         digit_limit [NUM_DIGITS];
  logic [OFFSET_W-1:0] digit_stride [NUM_DIGITS];
  logic [WIDX_W-1:0]   walk_count;
  walk_mode_e          walk_mode = MODE_SHUF_NCHW;
  bit                  walk_fresh;

  addr_word_t  addr_words [$];
  bit          pend_restart [$];
  bit          in_taken = 1'b0;
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;
  int unsigned err_count = 0;
  int unsigned words_checked = 0;
  int unsigned walks_seen = 0;
  int unsigned phase_count = 0;
  int unsigned words_queued = 0;

  function automatic longint unsigned clamp_size(longint unsigned v, longint unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  task automatic clear_walk();
    for (int k = 0; k < NUM_DIGITS; k++) walk_digit[k] = 0;
    walk_count = '0;
    walk_fresh = 1'b1;
  endtask

  task automatic predict_word(input logic rs);
    longint unsigned s, c, h, w, n, hw, ss, css, acc;
    longint unsigned st [NUM_DIGITS];
    bit              fin;
    int unsigned     k;
    addr_word_t      word;
    if (rs) clear_walk();
    if (walk_fresh) begin
      s = clamp_size(cfg_scale, MAX_FACTOR_DEF);
      c = clamp_size(cfg_chans, CHAN_MAX);
      h = clamp_size(cfg_height, HEIGHT_MAX);
      w = clamp_size(cfg_width, WIDTH_MAX);
      n = clamp_size(cfg_batch, BATCH_MAX);
      hw = h * w;
      ss = s * s;
      css = c * ss;
      walk_mode = walk_mode_e'({cfg_dir, cfg_lay});
      case (walk_mode)
        MODE_SHUF_NCHW: begin
          st = '{css * hw, ss * hw, w, s * hw, 1, hw};
        end
        MODE_SHUF_NHWC: begin
          st = '{hw * css, ss, w * css, s, css, 1};
        end
        MODE_UNSHUF_NCHW: begin
          st = '{css * hw, hw * ss, s * w * s, w * s, s, 1};
        end
        default: begin
          st = '{hw * css, 1, ss * w * c, w * s * c, s * c, c};
        end
      endcase
      for (int i = 0; i < NUM_DIGITS; i++) digit_stride[i] = st[i][OFFSET_W-1:0];
      digit_limit[DIG_BATCH]  = 32'(n);
      digit_limit[DIG_CHAN]   = 32'(c);
      digit_limit[DIG_ROW]    = 32'(h);
      digit_limit[DIG_SUBROW] = 32'(s);
      digit_limit[DIG_COL]    = 32'(w);
      digit_limit[DIG_SUBCOL] = 32'(s);
      walk_fresh = 1'b0;
    end
    acc = 0;
    fin = 1'b1;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      acc += longint'(walk_digit[i]) * longint'(digit_stride[i]);
      if (walk_digit[i] + 1 != digit_limit[i]) fin = 1'b0;
    end
    word.offset = acc[OFFSET_W-1:0];
    word.windex = walk_count;
    word.last   = fin;
    addr_words.push_back(word);
    walk_count = walk_count + 1'b1;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      k = WALK_ORDER[int'(walk_mode)][i];
      if (walk_digit[k] + 1 < digit_limit[k]) begin
        walk_digit[k]++;
        break;
      end
      walk_digit[k] = 0;
    end
    if (fin) clear_walk();
  endtask

  always @(posedge clk_i) begin
    addr_word_t want;
    in_taken <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o) predict_word(restart_i);
    if (out_valid_o && out_ready_i) begin
      if (addr_words.size() == 0) begin
        err_count++;
        $display("%0t: word with none expected, actual %h %h %b", $time,
                 read_offset_o, write_index_o, last_o);
      end else begin
        want = addr_words.pop_front();
        words_checked++;
        if (last_o === 1'b1) walks_seen++;
        if (read_offset_o !== want.offset) begin
          err_count++;
          $display("%0t: read_offset expected %h actual %h", $time, want.offset,
                   read_offset_o);
        end
        if (write_index_o !== want.windex) begin
          err_count++;
          $display("%0t: write_index expected %h actual %h", $time, want.windex,
                   write_index_o);
        end
        if (last_o !== want.last) begin
          err_count++;
          $display("%0t: last expected %b actual %b", $time, want.last, last_o);
        end
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (pend_restart.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        restart_i  <= pend_restart.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic wait_idle();
    while (pend_restart.size() != 0 || in_valid_i || addr_words.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      REG_DIRECTION: cfg_dir = data[0];
      REG_LAYOUT:    cfg_lay = data[0];
      REG_SCALE:     cfg_scale = data[SCALE_W-1:0];
      REG_CHANNELS:  cfg_chans = data[CHAN_W-1:0];
      REG_HEIGHT:    cfg_height = data[HEIGHT_W-1:0];
      REG_WIDTH:     cfg_width = data[WIDTH_W-1:0];
      default:       cfg_batch = data[BATCH_W-1:0];
    endcase
  endtask

  function automatic logic [CFG_DATA_W-1:0] with_junk(int unsigned v, int unsigned width,
                                                      bit junk);
    logic [CFG_DATA_W-1:0] r;
    r = CFG_DATA_W'(v & ((1 << width) - 1));
    if (junk) r = r | CFG_DATA_W'($urandom() << width);
    return r;
  endfunction

  task automatic load_config(input bit dir, input bit lay, input int unsigned s,
                             input int unsigned c, input int unsigned h,
                             input int unsigned w, input int unsigned n, input bit junk,
                             input int unsigned idle);
    wait_idle();
    write_reg(REG_DIRECTION, with_junk(dir, 1, junk));
    write_reg(REG_LAYOUT, with_junk(lay, 1, junk));
    write_reg(REG_SCALE, with_junk(s, SCALE_W, junk));
    write_reg(REG_CHANNELS, with_junk(c, CHAN_W, junk));
    write_reg(REG_HEIGHT, with_junk(h, HEIGHT_W, junk));
    write_reg(REG_WIDTH, with_junk(w, WIDTH_W, junk));
    write_reg(REG_BATCH, with_junk(n, BATCH_W, junk));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    send_gap_pct   = (idle == 1) ? 85 : (idle == 3) ? 32 : 0;
    recv_stall_pct = (idle == 2) ? 85 : (idle == 3) ? 32 : 0;
    phase_count++;
  endtask

  task automatic add_words(input int unsigned count, input int unsigned restart_pct,
                           input bit first_restart);
    for (int unsigned i = 0; i < count; i++) begin
      pend_restart.push_back((i == 0) ? first_restart : ($urandom_range(99) < restart_pct));
      words_queued++;
    end
  endtask

  initial begin
    int unsigned s, c, h, w, nb, wlen, count, rpct, rand_phase;
    logic [1:0]  mode;
    clear_walk();
    rand_phase = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: four-element walk, wrap past last, restart mid-walk
    phase_count++;
    pend_restart = '{0, 0, 0, 0, 0, 1, 0};
    words_queued += 7;
    // zero registers count as one; the change waits for the open walk to end
    load_config(0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_words(4, 0, 0);
    // above the maximum, upper write bits set
    load_config(1, 1, 15, 2047, 8191, 8191, 511, 1, 0);
    pend_restart = '{1, 0, 0, 0, 0, 1, 0, 0, 0, 0};
    words_queued += 10;
    // at the maximum
    load_config(0, 1, MAX_FACTOR_DEF, CHAN_MAX, HEIGHT_MAX, WIDTH_MAX, BATCH_MAX, 0, 0);
    add_words(6, 0, 1);

    while (words_queued < DIRECTED_WORDS + RANDOM_WORDS) begin
      mode = 2'($urandom_range(3));
      if ($urandom_range(7) == 0) begin
        s = $urandom_range(15);
        c = $urandom_range(2047);
        h = $urandom_range(8191);
        w = $urandom_range(8191);
        nb = $urandom_range(511);
        count = $urandom_range(20, 40);
        rpct = 10;
      end else begin
        s = $urandom_range(1, 3);
        c = $urandom_range(1, 2);
        h = $urandom_range(1, 3);
        w = $urandom_range(1, 3);
        nb = $urandom_range(1, 2);
        wlen = s * s * c * h * w * nb;
        count = wlen * $urandom_range(1, 3) + $urandom_range(2);
        if (count > 240) count = 240;
        rpct = 1;
      end
      load_config(mode[1], mode[0], s, c, h, w, nb, $urandom_range(3) == 0,
                  rand_phase % 4);
      add_words(count, rpct, $urandom_range(1));
      rand_phase++;
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (addr_words.size() != 0) begin
      err_count++;
      $display("%0t: %0d expected words never returned", $time, addr_words.size());
    end
    $display("%0d words checked over %0d register settings, %0d complete walks",
             words_checked, phase_count, walks_seen);
    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
    $display("testbench: errors");
    $finish;
  end

endmodule
